@@ sv/run_length_text_encoder_assert.svh @@
`ifndef RUN_LENGTH_TEXT_ENCODER_ASSERT_SVH
`define RUN_LENGTH_TEXT_ENCODER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define RLTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define RLTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rlte_pkg.sv @@
`timescale 1ns / 1ps

package rlte_pkg;

  // Longest run sent as one count
  localparam logic [15:0] MAX_RUN = 16'd65535;

  // Command queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Highest decimal digit position of a 16-bit count
  localparam logic [2:0] TopPos = 3'd4;

  // One run to send: symbol, count and item flags
  typedef struct packed {
    logic [7:0]  symbol;
    logic [15:0] length;
    logic        last;
    logic        line_done;
  } cmd_t;

  // Command plus its valid flag
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // Weight of a decimal digit position
  function automatic logic [13:0] pow10(input logic [2:0] pos);
    logic [13:0] w;
    case (pos)
      3'd0:    w = 14'd1;
      3'd1:    w = 14'd10;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd1000;
      default: w = 14'd10000;
    endcase
    return w;
  endfunction

  // Position of the leading digit of a count
  function automatic logic [2:0] start_pos(input logic [15:0] len);
    logic [2:0] p;
    if (len >= 16'd10000) begin
      p = 3'd4;
    end else if (len >= 16'd1000) begin
      p = 3'd3;
    end else if (len >= 16'd100) begin
      p = 3'd2;
    end else if (len >= 16'd10) begin
      p = 3'd1;
    end else begin
      p = 3'd0;
    end
    return p;
  endfunction

endpackage

@@ sv/rlte_if.sv @@
`timescale 1ns / 1ps

// Input channel: one raw byte of a line per item
interface rlte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_line;

  modport source (output valid, output symbol, output end_of_line, input ready);
  modport sink   (input valid, input symbol, input end_of_line, output ready);
endinterface

// Output channel: one encoded byte per item
interface rlte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       line_done;

  modport source (output valid, output out_byte, output last, output line_done, input ready);
  modport sink   (input valid, input out_byte, input last, input line_done, output ready);
endinterface

@@ sv/rlte_front.sv @@
`timescale 1ns / 1ps
`include "run_length_text_encoder_assert.svh"

module rlte_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  rlte_in_if.sink          in_i,
  output rlte_pkg::cmd_slot_t push_o,
  input  logic             full_i
);

  logic [7:0]     run_sym_q, run_sym_d;
  logic [15:0]    run_len_q, run_len_d;
  logic           pend_valid_q, pend_valid_d;
  rlte_pkg::cmd_t pend_cmd_q, pend_cmd_d;

  logic           accept;
  logic           flush_v, close_v;
  rlte_pkg::cmd_t flush_cmd, close_cmd;

  // Take a new item only when no second command is waiting and the queue has room
  assign in_i.ready = !pend_valid_q && !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the item against the open run
  always_comb begin
    run_sym_d = run_sym_q;
    run_len_d = run_len_q;
    flush_v   = 1'b0;
    close_v   = 1'b0;
    flush_cmd = '{symbol: run_sym_q, length: run_len_q,
                  last: !in_i.end_of_line, line_done: 1'b0};
    if (run_len_q == 16'd0) begin
      run_sym_d = in_i.symbol;
      run_len_d = 16'd1;
    end else if (in_i.symbol != run_sym_q || run_len_q >= rlte_pkg::MAX_RUN) begin
      flush_v   = 1'b1;
      run_sym_d = in_i.symbol;
      run_len_d = 16'd1;
    end else begin
      run_len_d = run_len_q + 16'd1;
    end
    close_cmd = '{symbol: run_sym_d, length: run_len_d, last: 1'b1, line_done: 1'b1};
    if (in_i.end_of_line) begin
      close_v   = 1'b1;
      run_sym_d = 8'd0;
      run_len_d = 16'd0;
    end
  end

  // Push a waiting command first, else the item's first command
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_cmd_d   = pend_cmd_q;
    push_o.valid = 1'b0;
    push_o.cmd   = flush_v ? flush_cmd : close_cmd;
    if (pend_valid_q) begin
      push_o.valid = !full_i;
      push_o.cmd   = pend_cmd_q;
      if (!full_i) begin
        pend_valid_d = 1'b0;
      end
    end else if (accept) begin
      push_o.valid = flush_v || close_v;
      if (flush_v && close_v) begin
        pend_valid_d = 1'b1;
        pend_cmd_d   = close_cmd;
      end
    end
  end

  // Hold run state and pending command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sym_q    <= 8'd0;
      run_len_q    <= 16'd0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        run_sym_q <= run_sym_d;
        run_len_q <= run_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cmd_q <= pend_cmd_d;
  end

  `RLTE_ASSERT_IMP(a_pend_blocks_input, pend_valid_q, !in_i.ready, "item taken while command pending")
  `RLTE_ASSERT_NEXT(a_pend_is_close, accept && flush_v && close_v, pend_valid_q && pend_cmd_q.line_done, "closing run not held")

endmodule

@@ sv/rlte_fifo.sv @@
`timescale 1ns / 1ps
`include "run_length_text_encoder_assert.svh"

module rlte_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlte_pkg::cmd_slot_t push_i,
  output logic                full_o,
  output rlte_pkg::cmd_slot_t head_o,
  input  logic                pop_i
);

  localparam int unsigned Aw = rlte_pkg::FifoAw;

  rlte_pkg::cmd_t  mem_q [rlte_pkg::FifoDepth];
  logic [Aw-1:0]   wptr_q, rptr_q;
  logic [Aw:0]     count_q;
  logic            do_pop;

  assign full_o       = (count_q == (Aw+1)'(rlte_pkg::FifoDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= wptr_q + Aw'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + Aw'(1);
      end
      if (push_i.valid && !do_pop) begin
        count_q <= count_q + (Aw+1)'(1);
      end else if (!push_i.valid && do_pop) begin
        count_q <= count_q - (Aw+1)'(1);
      end
    end
  end

  // Store pushed command
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wptr_q] <= push_i.cmd;
    end
  end

  `RLTE_ASSERT_IMP(a_no_overflow, push_i.valid, !full_o || do_pop, "push into full queue")
  `RLTE_ASSERT_IMP(a_no_underflow, pop_i, head_o.valid, "pop from empty queue")

endmodule

@@ sv/rlte_back.sv @@
`timescale 1ns / 1ps
`include "run_length_text_encoder_assert.svh"

module rlte_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlte_pkg::cmd_slot_t head_i,
  output logic                pop_o,
  rlte_out_if.source          out_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIG  = 2'b10
  } back_state_e;

  back_state_e st_q, st_d;
  logic [15:0] rem_q, rem_d;
  logic [2:0]  pos_q, pos_d;
  logic        last_q, last_d;
  logic        ld_q, ld_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        out_ld_q, out_ld_d;

  logic        advance;
  logic [13:0] weight;
  logic [16:0] kp, sub;
  logic [3:0]  dig;

  assign advance = !out_valid_q || out_o.ready;
  assign weight  = rlte_pkg::pow10(pos_q);

  // Pick the current digit by comparing against its multiples
  always_comb begin
    dig = 4'd0;
    sub = 17'd0;
    kp  = 17'd0;
    for (int k = 1; k <= 9; k++) begin
      kp = 17'(k) * {3'b000, weight};
      if ({1'b0, rem_q} >= kp) begin
        dig = 4'(k);
        sub = kp;
      end
    end
  end

  // Emit symbol, then the digits most significant first
  always_comb begin
    st_d        = st_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    last_d      = last_q;
    ld_d        = ld_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_ld_d    = out_ld_q;
    unique case (st_q)
      ST_IDLE: begin
        if (head_i.valid && advance) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = head_i.cmd.symbol;
          out_last_d  = 1'b0;
          out_ld_d    = 1'b0;
          rem_d       = head_i.cmd.length;
          pos_d       = rlte_pkg::start_pos(head_i.cmd.length);
          last_d      = head_i.cmd.last;
          ld_d        = head_i.cmd.line_done;
          st_d        = ST_DIG;
        end
      end
      ST_DIG: begin
        if (advance) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'h30 + {4'd0, dig};
          out_last_d  = (pos_q == 3'd0) && last_q;
          out_ld_d    = (pos_q == 3'd0) && ld_q;
          rem_d       = 16'({1'b0, rem_q} - sub);
          if (pos_q == 3'd0) begin
            st_d = ST_IDLE;
          end else begin
            pos_d = pos_q - 3'd1;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold conversion and output payload
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    pos_q      <= pos_d;
    last_q     <= last_d;
    ld_q       <= ld_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_ld_q   <= out_ld_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.last      = out_last_q;
  assign out_o.line_done = out_ld_q;

  `RLTE_ASSERT_IMP(a_rem_in_range, st_q == ST_DIG, ({1'b0, rem_q} < 17'd10 * {3'b000, weight}) && (pos_q <= rlte_pkg::TopPos), "digit remainder out of range")

endmodule

@@ sv/run_length_text_encoder.sv @@
`timescale 1ns / 1ps
// The first result byte of an item is written into the queue, then popped by the back
// end into its output register, and is presented from that register.
// Throughput: an item is taken every cycle while the queue has room and no command waits;
// an item that both sends the open run and closes the line holds the input until its closing command is queued.
// The back end sends one byte per cycle while the receiver is ready: a run's symbol, then the digits of its count.
// Reset (rst_ni low, asynchronous) clears the open run, the 4-entry queue and the output.

module run_length_text_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlte_in_if.sink    in_i,
  rlte_out_if.source out_o
);

  rlte_pkg::cmd_slot_t push, head;
  logic                full, pop;

  rlte_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .full_i (full)
  );

  rlte_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  rlte_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

@@ sim/tb_run_length_text_encoder.sv @@
`timescale 1ns / 1ps

// One encoded byte as it should leave the block
typedef struct packed {
  logic [7:0] out_byte;
  logic       last;
  logic       line_done;
} enc_byte_t;

// Run tracker for the encoder plus the queue of bytes still owed by the block
class rle_scoreboard;
  logic [7:0]  run_sym;
  int unsigned run_len;
  enc_byte_t   owed_q[$];
  int unsigned errors;
  int unsigned lines;
  int unsigned bytes_checked;
  int unsigned longest_run;

  function new();
    run_sym       = '0;
    run_len       = 0;
    errors        = 0;
    lines         = 0;
    bytes_checked = 0;
    longest_run   = 0;
  endfunction

  // Queue the symbol and then the decimal digits of its count
  function void push_run(logic [7:0] sym, int unsigned len);
    string     digits;
    enc_byte_t b;
    digits = $sformatf("%0d", len);
    b = '{sym, 1'b0, 1'b0};
    owed_q = {owed_q, b};
    for (int i = 0; i < digits.len(); i++) begin
      b.out_byte = digits[i];
      owed_q = {owed_q, b};
    end
    if (len > longest_run) begin
      longest_run = len;
    end
  endfunction

  // Advance the open run by one accepted byte and queue what it sends
  function void note_item(logic [7:0] sym, logic eol);
    int unsigned first;
    int unsigned tail;
    first = owed_q.size();
    if (run_len == 0) begin
      run_sym = sym;
      run_len = 1;
    end else if (sym != run_sym || run_len >= int'(rlte_pkg::MAX_RUN)) begin
      push_run(run_sym, run_len);
      run_sym = sym;
      run_len = 1;
    end else begin
      run_len++;
    end
    // Close the line: flush the open run and clear
    if (eol) begin
      push_run(run_sym, run_len);
      run_sym = '0;
      run_len = 0;
      lines++;
    end
    // Flag the final byte of this item
    if (owed_q.size() > first) begin
      tail = owed_q.size() - 1;
      owed_q[tail].last      = 1'b1;
      owed_q[tail].line_done = eol;
    end
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  // Print one line per mismatch (capped) and count all of them
  task flag_mismatch(string what);
    if (errors < 40) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    errors++;
  endtask

  // Compare one sent byte with the oldest owed byte
  task check_byte(logic [7:0] ob, logic lst, logic ld);
    enc_byte_t want;
    bytes_checked++;
    if (owed_q.size() == 0) begin
      flag_mismatch($sformatf("byte 0x%02h sent with nothing owed", ob));
      return;
    end
    want = owed_q.pop_front();
    if (ob !== want.out_byte) begin
      flag_mismatch($sformatf("out_byte 0x%02h, want 0x%02h", ob, want.out_byte));
    end
    if (lst !== want.last) begin
      flag_mismatch($sformatf("last %b, want %b (byte 0x%02h)", lst, want.last, ob));
    end
    if (ld !== want.line_done) begin
      flag_mismatch($sformatf("line_done %b, want %b (byte 0x%02h)", ld, want.line_done, ob));
    end
  endtask
endclass

module tb_run_length_text_encoder;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned PhaseQuota    = 48;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rlte_in_if  in_ch ();
  rlte_out_if out_ch ();

  rle_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;

  run_length_text_encoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Free-running clock
  always #4 clk_i = ~clk_i;

  // Abort when no item moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no item moved for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: check sent bytes, then pick ready for the next cycle
  initial begin
    int unsigned holds_done;
    int unsigned hold_left;
    holds_done = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        sb.check_byte(out_ch.out_byte, out_ch.last, out_ch.line_done);
      end
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one byte, idling first at random, and hold it until taken
  task automatic send_item(input logic [7:0] sym, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= sym;
    in_ch.end_of_line <= eol;
    @(posedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
    end
    sb.note_item(sym, eol);
    items_sent++;
  endtask

  // Send a run of one symbol, closing the line on its final byte
  task automatic send_run(input logic [7:0] sym, input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_item(sym, i == len - 1);
    end
  endtask

  // One well-formed line: mostly short runs, sometimes one long run
  task automatic send_random_line();
    int unsigned n;
    logic [7:0]  cur;
    bit          narrow;
    if ($urandom_range(11) == 0) begin
      send_run(8'($urandom_range(255)), $urandom_range(10, 110));
    end else begin
      n      = $urandom_range(1, 10);
      narrow = 1'($urandom_range(1));
      cur    = narrow ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom_range(255));
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(99) >= 55) begin
          cur = narrow ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom_range(255));
        end
        send_item(cur, i == n - 1);
      end
    end
  endtask

  // Drop valid, wait until every owed byte has come, then let the block settle
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Random lines under one idle/stall setting
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit hold);
    int unsigned start;
    start          = items_sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) begin
      hold_requests++;
    end
    while (items_sent - start < PhaseQuota) begin
      send_random_line();
    end
    wait_drain();
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.symbol      <= '0;
    in_ch.end_of_line <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines: field extremes, merge, change with end of line, two-digit count
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h41, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h42, 1'b1);
    send_run(8'hAA, 11);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h55, 1'b1);
    send_item(8'h30, 1'b0);
    send_item(8'h30, 1'b1);
    wait_drain();

    // Random lines: free flow with a long receiver hold, then idling mixes
    run_phase(0, 0, 1'b1);
    run_phase(62, 0, 1'b0);
    run_phase(0, 62, 1'b0);
    run_phase(25, 25, 1'b0);

    $display("Sent %0d bytes in %0d lines and checked %0d encoded bytes.",
             items_sent, sb.lines, sb.bytes_checked);
    $display("Longest count sent: %0d; idle, stall and long hold-off phases included.",
             sb.longest_run);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
